FILE: rtl/afd_pkg.sv
`default_nettype none

package afd_pkg;

  // Item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // Decode sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDB,
    ST_RDS,
    ST_EXEC
  } state_t;

  // Barrel shift kinds, from shift byte bits 2:1
  typedef enum logic [1:0] {
    SH_LSL,
    SH_LSR,
    SH_ASR,
    SH_ROR
  } shift_t;

  // Shift byte that leaves the operand untouched
  localparam logic [7:0] SHIFT_PASS = 8'h0B;

  // Register numbers with a fixed role
  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;

  // ARM load/store patterns
  localparam logic [31:0] ARM_SWP_MASK  = 32'h0FB0_0FF0;
  localparam logic [31:0] ARM_SWP_VAL   = 32'h0100_0090;
  localparam logic [31:0] ARM_SDT_MASK  = 32'h0C00_0000;
  localparam logic [31:0] ARM_SDT_VAL   = 32'h0400_0000;
  localparam logic [31:0] ARM_HW_MASK   = 32'h0E40_0F90;
  localparam logic [31:0] ARM_HWR_VAL   = 32'h0000_0090;
  localparam logic [31:0] ARM_HWI_VAL   = 32'h0040_0090;
  localparam logic [31:0] ARM_BLK_MASK  = 32'h0E00_0000;
  localparam logic [31:0] ARM_BLK_VAL   = 32'h0800_0000;

  // Thumb load/store patterns
  localparam logic [15:0] TH_LDRPC_MASK = 16'hF800;
  localparam logic [15:0] TH_LDRPC_VAL  = 16'h4800;
  localparam logic [15:0] TH_REGOFF_MASK = 16'hF200;
  localparam logic [15:0] TH_REGOFF_VAL = 16'h5000;
  localparam logic [15:0] TH_SEXT_VAL   = 16'h5200;
  localparam logic [15:0] TH_IMMW_MASK  = 16'hE000;
  localparam logic [15:0] TH_IMMW_VAL   = 16'h6000;
  localparam logic [15:0] TH_NIB_MASK   = 16'hF000;
  localparam logic [15:0] TH_IMMH_VAL   = 16'h8000;
  localparam logic [15:0] TH_SPREL_VAL  = 16'h9000;
  localparam logic [15:0] TH_PUSH_MASK  = 16'hF700;
  localparam logic [15:0] TH_PUSH_VAL   = 16'hB500;
  localparam logic [15:0] TH_LDM_VAL    = 16'hC000;

  // Base register number for a Thumb instruction
  function automatic logic [3:0] afd_thumb_base(input logic [15:0] op);
    logic [3:0] idx;
    idx = '0;
    if ((op & TH_LDRPC_MASK) == TH_LDRPC_VAL) begin
      idx = REG_PC;
    end else if (((op & TH_REGOFF_MASK) == TH_REGOFF_VAL) ||
                 ((op & TH_REGOFF_MASK) == TH_SEXT_VAL) ||
                 ((op & TH_IMMW_MASK) == TH_IMMW_VAL) ||
                 ((op & TH_NIB_MASK) == TH_IMMH_VAL)) begin
      idx = {1'b0, op[5:3]};
    end else if (((op & TH_NIB_MASK) == TH_SPREL_VAL) ||
                 ((op & TH_PUSH_MASK) == TH_PUSH_VAL)) begin
      idx = REG_SP;
    end else begin
      idx = {1'b0, op[10:8]};
    end
    return idx;
  endfunction

  // Offset register number for the Thumb register-offset forms
  function automatic logic [3:0] afd_thumb_index(input logic [15:0] op);
    return op[9] ? {2'b00, op[7:6]} : {1'b0, op[8:6]};
  endfunction

  // ARM barrel shifter driven by the shift byte
  function automatic logic [31:0] afd_barrel(input logic [31:0] v, input logic [7:0] sh,
                                             input logic [7:0] rs);
    logic [7:0]  amt;
    logic        big;
    logic [63:0] dbl;
    logic [31:0] res;
    amt = sh[0] ? rs : {3'b000, sh[7:3]};
    big = (amt[7:5] != 3'b000);
    dbl = {v, v} >> amt[4:0];
    case (shift_t'(sh[2:1]))
      SH_LSL:  res = big ? '0 : (v << amt[4:0]);
      SH_LSR:  res = big ? '0 : (v >> amt[4:0]);
      SH_ASR:  res = big ? {32{v[31]}} : 32'($signed(v) >>> amt[4:0]);
      SH_ROR:  res = dbl[31:0];
      default: res = v;
    endcase
    if (sh == SHIFT_PASS) begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/arm_fault_address_decoder.sv
// ARM / Thumb data abort address decoder.
//
// Input channel (in_valid / in_stall) carries one request per accept. A
// request with kind 0 writes reg_value into saved register reg_index and
// gives no result. A request with kind 1 decodes opcode (Thumb when thumb is
// set, low 16 bits only) against the load/store patterns and returns the
// accessed data address on the output channel (out_valid / out_stall), with
// matched low and address zero for an opcode that fits no pattern.
//
// Saved registers live in a 16 x 32 synchronous RAM with one read port. A
// decode issues three reads (base, offset register, shift amount register)
// on successive cycles, in IDLE (the accepting cycle), RDB and RDS, and
// forms the address in EXEC, from which the output register is loaded. No
// request is accepted until the sequencer is back in IDLE. A register write
// is taken in its accepting cycle, so writes may follow back to back.
//
// Reset clears a valid bit per register, so every saved register reads as
// zero until written. A result waits in the output register while
// out_stall is high; the next request may be accepted meanwhile, and its
// decode holds in the last step until the output register is free.
`default_nettype none

module arm_fault_address_decoder
  import afd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [3:0]  reg_index,
  input  wire logic [31:0] reg_value,
  input  wire logic [31:0] opcode,
  input  wire logic        thumb,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      fault_address,
  output logic             matched
);

  // Saved register RAM and per-entry valid bits
  logic [31:0] regs [16];
  logic [15:0] reg_valid;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic        rd_valid;
  logic [31:0] rd_out;

  state_t      state, state_next;
  logic [31:0] op;
  logic        op_thumb;
  logic [31:0] base;
  logic [31:0] opb;

  logic        in_fire;
  logic        wr_en;
  logic        exec_fire;

  logic [31:0] shifted;
  logic [31:0] offset;
  logic        sub;
  logic        hit;
  logic [31:0] addr;

  assign in_fire   = in_valid && !in_stall;
  assign wr_en     = in_fire && (kind == KIND_WRITE);
  assign exec_fire = (state == ST_EXEC) && (!out_valid || !out_stall);
  assign in_stall  = (state != ST_IDLE);
  assign rd_out    = rd_valid ? rd_data : '0;

  // Pick read address for the current step
  always_comb begin
    case (state)
      ST_IDLE: rd_addr = thumb ? afd_thumb_base(opcode[15:0]) : opcode[19:16];
      ST_RDB:  rd_addr = op_thumb ? afd_thumb_index(op[15:0]) : op[3:0];
      ST_RDS:  rd_addr = op[11:8];
      default: rd_addr = op[11:8];
    endcase
  end

  // Write and read the register RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[reg_index] <= reg_value;
    end
    rd_data <= regs[rd_addr];
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= reg_valid[rd_addr];
      if (wr_en) begin
        reg_valid[reg_index] <= 1'b1;
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire && (kind == KIND_DECODE)) state_next = ST_RDB;
      ST_RDB:  state_next = ST_RDS;
      ST_RDS:  state_next = ST_EXEC;
      ST_EXEC: if (exec_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture request and operands
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op       <= opcode;
      op_thumb <= thumb;
    end
    if (state == ST_RDB) begin
      base <= rd_out;
    end
    if (state == ST_RDS) begin
      opb <= rd_out;
    end
  end

  // Decode and form the address; the shift amount register is on rd_out
  always_comb begin
    shifted = afd_barrel(opb, op[11:4], rd_out[7:0]);
    offset  = '0;
    sub     = 1'b0;
    hit     = 1'b1;
    if (op_thumb) begin
      if ((op[15:0] & TH_LDRPC_MASK) == TH_LDRPC_VAL) begin
        offset = {{24{op[7]}}, op[7:0]};
      end else if (((op[15:0] & TH_REGOFF_MASK) == TH_REGOFF_VAL) ||
                   ((op[15:0] & TH_REGOFF_MASK) == TH_SEXT_VAL)) begin
        offset = opb;
      end else if (((op[15:0] & TH_IMMW_MASK) == TH_IMMW_VAL) ||
                   ((op[15:0] & TH_NIB_MASK) == TH_IMMH_VAL)) begin
        offset = {25'd0, op[10:6], 2'b00};
      end else if ((op[15:0] & TH_NIB_MASK) == TH_SPREL_VAL) begin
        offset = {{24{op[7]}}, op[7:0]};
      end else if (((op[15:0] & TH_PUSH_MASK) == TH_PUSH_VAL) ||
                   ((op[15:0] & TH_NIB_MASK) == TH_LDM_VAL)) begin
        offset = '0;
      end else begin
        hit = 1'b0;
      end
    end else begin
      if ((op & ARM_SWP_MASK) == ARM_SWP_VAL) begin
        offset = '0;
      end else if ((op & ARM_SDT_MASK) == ARM_SDT_VAL) begin
        if (op[24]) begin
          sub    = !op[23];
          offset = op[25] ? shifted : {20'd0, op[11:0]};
        end
      end else if ((op & ARM_HW_MASK) == ARM_HWR_VAL) begin
        sub    = !op[23];
        offset = shifted;
      end else if ((op & ARM_HW_MASK) == ARM_HWI_VAL) begin
        sub    = !op[23];
        offset = {24'd0, op[11:8], op[3:0]};
      end else if ((op & ARM_BLK_MASK) == ARM_BLK_VAL) begin
        offset = '0;
      end else begin
        hit = 1'b0;
      end
    end
    addr = sub ? (base - offset) : (base + offset);
    if (!hit) begin
      addr = '0;
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      fault_address <= addr;
      matched       <= hit;
    end
  end

  // A result appears only out of the final decode step
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EXEC)
    else $error("result without decode");

  // An unmatched opcode reports address zero
  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !matched) |-> fault_address == '0)
    else $error("unmatched opcode with nonzero address");

  // A decode request walks through the read steps RDB and RDS into EXEC
  a_decode_walk: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (kind == KIND_DECODE)) |=>
      (state == ST_RDB) ##1 (state == ST_RDS) ##1 (state == ST_EXEC))
    else $error("decode sequence broken");

  // No request is taken while a decode is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_fire)
    else $error("request accepted during decode");

endmodule

`default_nettype wire

FILE: tb/arm_fault_address_decoder_test.sv
`timescale 1ns / 100ps

module arm_fault_address_decoder_test;
  import afd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [31:0] address;
    logic        hit;
  } fault_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [3:0]  reg_index;
  logic [31:0] reg_value;
  logic [31:0] opcode;
  logic        thumb;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] fault_address;
  logic        matched;

  // Shadow copy of the saved registers and the results still owed
  logic [31:0]   saved_regs [16];
  fault_result_t pending_results [$];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served;
  int cycle_count = 0;
  bit failed = 1'b0;

  arm_fault_address_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .reg_index    (reg_index),
    .reg_value    (reg_value),
    .opcode       (opcode),
    .thumb        (thumb),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fault_address(fault_address),
    .matched      (matched)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Barrel-shift an offset register by the instruction's shift byte
  function automatic logic [31:0] shifted_operand(input logic [31:0] v, input logic [7:0] sh);
    logic [7:0] amount;
    if (sh == SHIFT_PASS) return v;
    amount = sh[0] ? saved_regs[sh[7:4]][7:0] : {3'b000, sh[7:3]};
    if (amount == 8'd0) return v;
    case (shift_t'(sh[2:1]))
      SH_LSL:  return (amount >= 8'd32) ? 32'h0 : (v << amount);
      SH_LSR:  return (amount >= 8'd32) ? 32'h0 : (v >> amount);
      SH_ASR:  return (amount >= 8'd32) ? {32{v[31]}} : $unsigned($signed(v) >>> amount);
      default: begin
        if (amount[4:0] == 5'd0) return v;
        return (v >> amount[4:0]) | (v << (6'd32 - {1'b0, amount[4:0]}));
      end
    endcase
  endfunction

  // Work out the data address that a faulting instruction touched
  function automatic fault_result_t predict_fault(input logic [31:0] op, input logic th);
    fault_result_t r;
    logic [15:0]   h;
    logic [31:0]   base;
    logic [31:0]   offset;
    r.address = '0;
    r.hit = 1'b1;
    h = op[15:0];
    base = saved_regs[op[19:16]];
    if (th) begin
      if ((h & TH_LDRPC_MASK) == TH_LDRPC_VAL)
        r.address = saved_regs[REG_PC] + {{24{h[7]}}, h[7:0]};
      else if ((h & TH_REGOFF_MASK) == TH_REGOFF_VAL)
        r.address = saved_regs[{1'b0, h[5:3]}] + saved_regs[{1'b0, h[8:6]}];
      else if ((h & TH_REGOFF_MASK) == TH_SEXT_VAL)
        r.address = saved_regs[{1'b0, h[5:3]}] + saved_regs[{2'b00, h[7:6]}];
      else if (((h & TH_IMMW_MASK) == TH_IMMW_VAL) || ((h & TH_NIB_MASK) == TH_IMMH_VAL))
        r.address = saved_regs[{1'b0, h[5:3]}] + {25'h0, h[10:6], 2'b00};
      else if ((h & TH_NIB_MASK) == TH_SPREL_VAL)
        r.address = saved_regs[REG_SP] + {{24{h[7]}}, h[7:0]};
      else if ((h & TH_PUSH_MASK) == TH_PUSH_VAL)
        r.address = saved_regs[REG_SP];
      else if ((h & TH_NIB_MASK) == TH_LDM_VAL)
        r.address = saved_regs[{1'b0, h[10:8]}];
      else
        r.hit = 1'b0;
    end else begin
      if ((op & ARM_SWP_MASK) == ARM_SWP_VAL) begin
        r.address = base;
      end else if ((op & ARM_SDT_MASK) == ARM_SDT_VAL) begin
        if (!op[24]) begin
          r.address = base;
        end else begin
          offset = op[25] ? shifted_operand(saved_regs[op[3:0]], op[11:4]) : {20'h0, op[11:0]};
          r.address = op[23] ? base + offset : base - offset;
        end
      end else if ((op & ARM_HW_MASK) == ARM_HWR_VAL) begin
        offset = shifted_operand(saved_regs[op[3:0]], op[11:4]);
        r.address = op[23] ? base + offset : base - offset;
      end else if ((op & ARM_HW_MASK) == ARM_HWI_VAL) begin
        offset = {24'h0, op[11:8], op[3:0]};
        r.address = op[23] ? base + offset : base - offset;
      end else if ((op & ARM_BLK_MASK) == ARM_BLK_VAL) begin
        r.address = base;
      end else begin
        r.hit = 1'b0;
      end
    end
    if (!r.hit) r.address = '0;
    return r;
  endfunction

  // Force a pattern onto random bits
  function automatic logic [31:0] with_pattern(input logic [31:0] raw, input logic [31:0] mask,
                                               input logic [31:0] val);
    return (raw & ~mask) | val;
  endfunction

  function automatic logic [31:0] random_register_value();
    case ($urandom_range(5))
      0:       return 32'($urandom_range(40));
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_thumb_opcode();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return with_pattern(raw, 32'(TH_LDRPC_MASK), 32'(TH_LDRPC_VAL));
      1:       return with_pattern(raw, 32'(TH_REGOFF_MASK), 32'(TH_REGOFF_VAL));
      2:       return with_pattern(raw, 32'(TH_REGOFF_MASK), 32'(TH_SEXT_VAL));
      3:       return with_pattern(raw, 32'(TH_IMMW_MASK), 32'(TH_IMMW_VAL));
      4:       return with_pattern(raw, 32'(TH_NIB_MASK), 32'(TH_IMMH_VAL));
      5:       return with_pattern(raw, 32'(TH_NIB_MASK), 32'(TH_SPREL_VAL));
      6:       return with_pattern(raw, 32'(TH_PUSH_MASK), 32'(TH_PUSH_VAL));
      7:       return with_pattern(raw, 32'(TH_NIB_MASK), 32'(TH_LDM_VAL));
      default: return raw;
    endcase
  endfunction

  function automatic logic [31:0] random_arm_opcode();
    logic [31:0] raw;
    raw = $urandom;
    // bias the shift byte toward the pass-through value now and then
    if ($urandom_range(7) == 0) raw[11:4] = SHIFT_PASS;
    case ($urandom_range(7))
      0:       return with_pattern(raw, ARM_SWP_MASK, ARM_SWP_VAL);
      1, 2:    return with_pattern(raw, ARM_SDT_MASK, ARM_SDT_VAL);
      3:       return with_pattern(raw, ARM_HW_MASK, ARM_HWR_VAL);
      4:       return with_pattern(raw, ARM_HW_MASK, ARM_HWI_VAL);
      5:       return with_pattern(raw, ARM_BLK_MASK, ARM_BLK_VAL);
      default: return raw;
    endcase
  endfunction

  // Offer one request, hold it until accepted, then update the shadow state
  task automatic send_request(input logic k, input logic [3:0] idx, input logic [31:0] val,
                              input logic [31:0] op, input logic th);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    reg_index <= idx;
    reg_value <= val;
    opcode    <= op;
    thumb     <= th;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (k == KIND_WRITE)
      saved_regs[idx] = val;
    else
      pending_results.push_back(predict_fault(op, th));
  endtask

  task automatic send_random_item();
    logic [31:0] noise;
    noise = $urandom;
    if ($urandom_range(3) == 0)
      send_request(KIND_WRITE, 4'($urandom_range(15)), random_register_value(), noise,
                   noise[31]);
    else if (noise[0])
      send_request(KIND_DECODE, noise[7:4], $urandom, random_thumb_opcode(), 1'b1);
    else
      send_request(KIND_DECODE, noise[7:4], $urandom, random_arm_opcode(), 1'b0);
  endtask

  // Drop valid and wait until every owed result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_register_writes();
    send_request(KIND_WRITE, REG_PC, 32'h1000_0000, 32'hFFFF_FFFF, 1'b1);
    send_request(KIND_WRITE, REG_SP, 32'h2000_0000, 32'h0, 1'b0);
    send_request(KIND_WRITE, 4'd1, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_request(KIND_WRITE, 4'd2, 32'h8000_0000, 32'h0, 1'b0);
    send_request(KIND_WRITE, 4'd3, 32'd40, 32'h0, 1'b0);
    send_request(KIND_WRITE, 4'd4, 32'd0, 32'h0, 1'b0);
  endtask

  // One of each Thumb form, plus an opcode that fits none
  task automatic test_thumb_forms();
    send_request(KIND_DECODE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_48FF, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'h0000_5088, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'h0000_52D0, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'h0000_7FFF, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'h0000_87C8, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hABCD_9080, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'h0000_BDFF, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'h0000_C7FF, 1'b1);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hFFFF_0000, 1'b1);
  endtask

  // ARM forms: swap, single transfer modes, shifts at their edges, halfword, block, and an opcode that fits none
  task automatic test_arm_forms();
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE101_0095, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE491_0004, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE591_0FFF, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE511_0FFF, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE791_0352, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE791_0472, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE791_0042, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE711_0FA1, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE791_00B2, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE191_00F2, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE1D1_00BF, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hE8BD_0000, 1'b0);
    send_request(KIND_DECODE, 4'h0, 32'h0, 32'hEE00_0000, 1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int hold_pct, input int count);
    sender_idle_pct = idle_pct;
    stall_pct = hold_pct;
    repeat (count) send_random_item();
    wait_for_results();
  endtask

  // Hold the output for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (40) send_random_item();
    wait_for_results();
  endtask

  // Drive out_stall; a hold request forces a long stall
  initial begin
    int hold_left;
    hold_left = 0;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    fault_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: address %h matched %b", $time, fault_address,
                 matched);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (fault_address !== want.address) begin
          $display("%0t: fault_address expected %h actual %h", $time, want.address,
                   fault_address);
          failed = 1'b1;
        end
        if (matched !== want.hit) begin
          $display("%0t: matched expected %b actual %b", $time, want.hit, matched);
          failed = 1'b1;
        end
      end
    end
  end

  // Bound the run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_WRITE;
    reg_index = '0;
    reg_value = '0;
    opcode = '0;
    thumb = 1'b0;
    for (int i = 0; i < 16; i++) saved_regs[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_register_writes();
    test_thumb_forms();
    test_arm_forms();
    wait_for_results();
    test_random_traffic(0, 0, 400);
    test_random_traffic(47, 0, 400);
    test_random_traffic(0, 47, 400);
    test_random_traffic(10, 10, 400);
    test_output_backpressure();

    if (!failed)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
